[rtl/core/hnm_pkg.sv]
// Shared types, sizes and helpers of the Hamming nearest-match block.
// No dependencies; the top level and hnm_dist refer to it by scoped names.

package hnm_pkg;

	// Pattern store geometry
	localparam int MAX_LEVELS  = 16;
	localparam int MAX_ENTRIES = 512;
	localparam int DEPTH       = MAX_LEVELS * MAX_ENTRIES;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int LEVEL_W     = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int ENTRY_W     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int NLEV_W      = $clog2(MAX_LEVELS + 1);
	localparam int NENT_W      = $clog2(MAX_ENTRIES + 1);

	// Fixed field widths
	localparam int LEVEL_IN_W  = 4;
	localparam int ENTRY_IN_W  = 9;
	localparam int QIDX_W      = 10;
	localparam int WORD_W      = 64;
	localparam int NUM_WORDS   = 4;
	localparam int DESC_W      = WORD_W * NUM_WORDS;
	localparam int PC_W        = $clog2(WORD_W + 1);
	localparam int DIST_W      = 9;
	localparam int FRAC_W      = 8;
	localparam int RATIO_W     = 9;
	localparam int PROD_W      = RATIO_W + DIST_W;

	localparam logic [DIST_W-1:0] DIST_NONE = DIST_W'(DESC_W);

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;
	localparam int ALEV_W     = 5;
	localparam int EPL_W      = 10;
	localparam int THR_W      = 9;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACTIVE_LEVELS = 3'd0,
		CFG_ENTRIES       = 3'd1,
		CFG_THRESHOLD     = 3'd2,
		CFG_RATIO         = 3'd3
	} cfg_reg_t;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	// Tag that travels with each store read through the distance pipeline
	typedef struct packed {
		logic               vld;
		logic [LEVEL_W-1:0] lev;
		logic [ENTRY_W-1:0] ent;
	} tag_t;

	// Balanced adder tree: pair, nibble, byte, 16-bit, half-word and word sums
	function automatic logic [PC_W-1:0] popcount64(input logic [WORD_W-1:0] x);
		logic [1:0] p2  [32];
		logic [2:0] p4  [16];
		logic [3:0] p8  [8];
		logic [4:0] p16 [4];
		logic [5:0] p32 [2];
		for (int i = 0; i < 32; i++) begin
			p2[i] = 2'(x[2*i]) + 2'(x[2*i+1]);
		end
		for (int i = 0; i < 16; i++) begin
			p4[i] = 3'(p2[2*i]) + 3'(p2[2*i+1]);
		end
		for (int i = 0; i < 8; i++) begin
			p8[i] = 4'(p4[2*i]) + 4'(p4[2*i+1]);
		end
		for (int i = 0; i < 4; i++) begin
			p16[i] = 5'(p8[2*i]) + 5'(p8[2*i+1]);
		end
		for (int i = 0; i < 2; i++) begin
			p32[i] = 6'(p16[2*i]) + 6'(p16[2*i+1]);
		end
		return PC_W'(p32[0]) + PC_W'(p32[1]);
	endfunction

endpackage

[rtl/core/hamming_nearest_match_ratio_test.sv]
// Top level of the brute-force Hamming matcher with threshold and ratio test.
// Depends on hnm_pkg, hnm_ram (pattern store) and hnm_dist (distance stage).

// Usage
//   Request channel: a request is taken at a rising edge with start high and
//   busy low. operation selects load or query. A load writes word0..word3
//   into the store at (level, entry_index) in that one cycle when both are in
//   range; busy stays low, so loads stream one per cycle and give no result.
//   A query scans entries 0..E-1 of levels 0..L-1 (L, E = configured counts,
//   clamped to the store size), one store read per cycle on the single RAM
//   port. busy is high from acceptance until the result. When the scan has
//   drained, the result shows up as a one-cycle result_valid strobe with
//   match_found, matched_query, best_level, best_entry, best_distance and
//   second_distance. A new request can be taken in the strobe cycle.
//   The receiver cannot stall; each result is presented for one cycle only.
//   Configuration: cfg_valid/cfg_ready write channel, always ready; index 0
//   active levels, 1 entries per level, 2 distance threshold, 3 ratio (Q1.8).
//   Other indexes are dropped. Write only while the block is idle.
//   Reset (arst_n low): registers take their defaults, scan stops, no result
//   is pending. The pattern store is not cleared; load entries before query.

module hamming_nearest_match_ratio_test (
	input  logic                                clk,
	input  logic                                arst_n,
	// request channel
	input  logic                                start,
	output logic                                busy,
	input  logic                                operation,
	input  logic [hnm_pkg::LEVEL_IN_W-1:0]      level,
	input  logic [hnm_pkg::ENTRY_IN_W-1:0]      entry_index,
	input  logic [hnm_pkg::QIDX_W-1:0]          query_index,
	input  logic [hnm_pkg::WORD_W-1:0]          word0,
	input  logic [hnm_pkg::WORD_W-1:0]          word1,
	input  logic [hnm_pkg::WORD_W-1:0]          word2,
	input  logic [hnm_pkg::WORD_W-1:0]          word3,
	// configuration channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [hnm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [hnm_pkg::CFG_DATA_W-1:0]      cfg_data,
	// result channel
	output logic                                result_valid,
	output logic                                match_found,
	output logic [hnm_pkg::QIDX_W-1:0]          matched_query,
	output logic [hnm_pkg::LEVEL_IN_W-1:0]      best_level,
	output logic [hnm_pkg::ENTRY_IN_W-1:0]      best_entry,
	output logic [hnm_pkg::DIST_W-1:0]          best_distance,
	output logic [hnm_pkg::DIST_W-1:0]          second_distance
);

	// Configuration registers
	logic [hnm_pkg::ALEV_W-1:0]   active_levels_q;
	logic [hnm_pkg::EPL_W-1:0]    entries_per_level_q;
	logic [hnm_pkg::THR_W-1:0]    distance_threshold_q;
	logic [hnm_pkg::RATIO_W-1:0]  ratio_q8_q;

	// Control
	hnm_pkg::state_t              state_q, state_d;
	logic [hnm_pkg::NLEV_W-1:0]   nlev_q, nlev_c;
	logic [hnm_pkg::NENT_W-1:0]   nent_q, nent_c;
	logic [hnm_pkg::LEVEL_W-1:0]  lev_q;
	logic [hnm_pkg::ENTRY_W-1:0]  ent_q;
	logic                         accept, accept_query, accept_load;
	logic                         issue, ent_last, lev_last, pipe_empty, report;

	// Query data and running best/second
	logic [hnm_pkg::DESC_W-1:0]   query_q;
	logic [hnm_pkg::QIDX_W-1:0]   qidx_q;
	logic [hnm_pkg::DIST_W-1:0]   best_q, second_q;
	logic [hnm_pkg::LEVEL_W-1:0]  best_lev_q;
	logic [hnm_pkg::ENTRY_W-1:0]  best_ent_q;

	// Store access
	logic                         ram_we;
	logic [hnm_pkg::ADDR_W-1:0]   ram_addr, load_addr, scan_addr;
	logic [hnm_pkg::DESC_W-1:0]   ram_wdata, ram_rdata;
	logic                         load_in_range;

	hnm_pkg::tag_t                tag_s1, tag_s2;
	logic [hnm_pkg::DIST_W-1:0]   dist_s2;

	// Match test
	logic [hnm_pkg::PROD_W-1:0]   best_scaled, ratio_prod;
	logic                         match_c;

	assign cfg_ready = 1'b1;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_levels_q      <= hnm_pkg::ALEV_W'(10);
			entries_per_level_q  <= hnm_pkg::EPL_W'(500);
			distance_threshold_q <= hnm_pkg::THR_W'(95);
			ratio_q8_q           <= hnm_pkg::RATIO_W'(204);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				hnm_pkg::CFG_ACTIVE_LEVELS: active_levels_q <= cfg_data[hnm_pkg::ALEV_W-1:0];
				hnm_pkg::CFG_ENTRIES:       entries_per_level_q <= cfg_data[hnm_pkg::EPL_W-1:0];
				hnm_pkg::CFG_THRESHOLD:     distance_threshold_q <= cfg_data[hnm_pkg::THR_W-1:0];
				hnm_pkg::CFG_RATIO:         ratio_q8_q <= cfg_data[hnm_pkg::RATIO_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the scan extent to the store size
	assign nlev_c = (32'(active_levels_q) > hnm_pkg::MAX_LEVELS)
		? hnm_pkg::NLEV_W'(hnm_pkg::MAX_LEVELS) : hnm_pkg::NLEV_W'(active_levels_q);
	assign nent_c = (32'(entries_per_level_q) > hnm_pkg::MAX_ENTRIES)
		? hnm_pkg::NENT_W'(hnm_pkg::MAX_ENTRIES) : hnm_pkg::NENT_W'(entries_per_level_q);

	// ---------------------------------------------------------------- store
	assign load_in_range = (32'(level) < hnm_pkg::MAX_LEVELS)
		&& (32'(entry_index) < hnm_pkg::MAX_ENTRIES);
	assign load_addr = hnm_pkg::ADDR_W'(32'(level) * hnm_pkg::MAX_ENTRIES + 32'(entry_index));
	assign scan_addr = hnm_pkg::ADDR_W'(32'(lev_q) * hnm_pkg::MAX_ENTRIES + 32'(ent_q));
	assign ram_wdata = {word3, word2, word1, word0};

	assign busy         = (state_q != hnm_pkg::ST_IDLE);
	assign accept       = start && !busy;
	assign accept_query = accept && (operation == hnm_pkg::OP_QUERY);
	assign accept_load  = accept && (operation == hnm_pkg::OP_LOAD);

	assign ram_we   = accept_load && load_in_range;
	assign ram_addr = (state_q == hnm_pkg::ST_SCAN) ? scan_addr : load_addr;

	hnm_ram #(
		.WIDTH (hnm_pkg::DESC_W),
		.DEPTH (hnm_pkg::DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// ---------------------------------------------------------------- FSM
	assign ent_last   = (hnm_pkg::NENT_W'(ent_q) + hnm_pkg::NENT_W'(1)) == nent_q;
	assign lev_last   = (hnm_pkg::NLEV_W'(lev_q) + hnm_pkg::NLEV_W'(1)) == nlev_q;
	assign pipe_empty = !tag_s1.vld && !tag_s2.vld;

	always_comb begin
		state_d = state_q;
		issue   = 1'b0;
		report  = 1'b0;
		unique case (state_q)
			hnm_pkg::ST_IDLE: begin
				if (accept_query) begin
					// empty scan extent: go straight to reporting the defaults
					if (nlev_c == '0 || nent_c == '0) begin
						state_d = hnm_pkg::ST_DRAIN;
					end else begin
						state_d = hnm_pkg::ST_SCAN;
					end
				end
			end
			hnm_pkg::ST_SCAN: begin
				issue = 1'b1;
				if (ent_last && lev_last) begin
					state_d = hnm_pkg::ST_DRAIN;
				end
			end
			hnm_pkg::ST_DRAIN: begin
				// wait for the last distance to fold into best/second
				if (pipe_empty) begin
					report  = 1'b1;
					state_d = hnm_pkg::ST_IDLE;
				end
			end
			default: state_d = hnm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hnm_pkg::ST_IDLE;
			lev_q   <= '0;
			ent_q   <= '0;
			nlev_q  <= '0;
			nent_q  <= '0;
			tag_s1  <= '0;
		end else begin
			state_q    <= state_d;
			tag_s1.vld <= issue;
			tag_s1.lev <= lev_q;
			tag_s1.ent <= ent_q;
			if (accept_query) begin
				lev_q  <= '0;
				ent_q  <= '0;
				nlev_q <= nlev_c;
				nent_q <= nent_c;
			end else if (issue) begin
				// advance entry first, then level
				if (ent_last) begin
					ent_q <= '0;
					lev_q <= lev_q + hnm_pkg::LEVEL_W'(1);
				end else begin
					ent_q <= ent_q + hnm_pkg::ENTRY_W'(1);
				end
			end
		end
	end

	// ---------------------------------------------------------------- distance
	hnm_dist u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.query   (query_q),
		.pattern (ram_rdata),
		.tag_s1  (tag_s1),
		.tag_s2  (tag_s2),
		.dist_s2 (dist_s2)
	);

	// Hold the query descriptor for the whole scan
	always_ff @(posedge clk) begin
		if (accept_query) begin
			query_q <= ram_wdata;
			qidx_q  <= query_index;
		end
	end

	// Best/second tracking; strict compares keep the earlier entry on ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q     <= hnm_pkg::DIST_NONE;
			second_q   <= hnm_pkg::DIST_NONE;
			best_lev_q <= '0;
			best_ent_q <= '0;
		end else if (accept_query) begin
			best_q     <= hnm_pkg::DIST_NONE;
			second_q   <= hnm_pkg::DIST_NONE;
			best_lev_q <= '0;
			best_ent_q <= '0;
		end else if (tag_s2.vld) begin
			if (dist_s2 < best_q) begin
				second_q   <= best_q;
				best_q     <= dist_s2;
				best_lev_q <= tag_s2.lev;
				best_ent_q <= tag_s2.ent;
			end else if (dist_s2 < second_q) begin
				second_q <= dist_s2;
			end
		end
	end

	// ---------------------------------------------------------------- result
	assign best_scaled = hnm_pkg::PROD_W'({best_q, hnm_pkg::FRAC_W'(0)});
	assign ratio_prod  = hnm_pkg::PROD_W'(ratio_q8_q) * hnm_pkg::PROD_W'(second_q);
	assign match_c     = (hnm_pkg::THR_W'(best_q) < distance_threshold_q)
		&& (best_scaled < ratio_prod);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= report;
		end
	end

	always_ff @(posedge clk) begin
		if (report) begin
			match_found     <= match_c;
			matched_query   <= qidx_q;
			best_level      <= hnm_pkg::LEVEL_IN_W'(best_lev_q);
			best_entry      <= hnm_pkg::ENTRY_IN_W'(best_ent_q);
			best_distance   <= best_q;
			second_distance <= second_q;
		end
	end

	// ---------------------------------------------------------------- checks
	a_best_le_second: assert property (@(posedge clk) disable iff (!arst_n)
		best_q <= second_q)
		else $error("best distance above second distance");

	a_result_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q == hnm_pkg::ST_DRAIN))
		else $error("result strobe without a finished scan");

	a_pipe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hnm_pkg::ST_IDLE) |-> !tag_s2.vld)
		else $error("distance pipeline active while idle");

	a_no_store_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hnm_pkg::ST_SCAN) |-> !ram_we)
		else $error("store written during a scan");

endmodule

[rtl/core/hnm_ram.sv]
// Generic single-port synchronous RAM with registered read data.
// Depends on nothing; width and depth come from its parameters.

module hnm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

[rtl/core/hnm_dist.sv]
// Distance stage: XOR of query and stored descriptor, registered word popcounts.
// Depends on hnm_pkg for sizes, the tag type and the popcount helper.

module hnm_dist (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [hnm_pkg::DESC_W-1:0]    query,
	input  logic [hnm_pkg::DESC_W-1:0]    pattern,
	input  hnm_pkg::tag_t                 tag_s1,
	output hnm_pkg::tag_t                 tag_s2,
	output logic [hnm_pkg::DIST_W-1:0]    dist_s2
);

	logic [hnm_pkg::DESC_W-1:0]                         diff;
	logic [hnm_pkg::NUM_WORDS-1:0][hnm_pkg::PC_W-1:0]   pc_s2;

	assign diff = query ^ pattern;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else begin
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int w = 0; w < hnm_pkg::NUM_WORDS; w++) begin
			pc_s2[w] <= hnm_pkg::popcount64(diff[w*hnm_pkg::WORD_W +: hnm_pkg::WORD_W]);
		end
	end

	always_comb begin
		dist_s2 = '0;
		for (int w = 0; w < hnm_pkg::NUM_WORDS; w++) begin
			dist_s2 = dist_s2 + hnm_pkg::DIST_W'(pc_s2[w]);
		end
	end

endmodule

[tb/tb_hamming_nearest_match_ratio_test.sv]
// Self-checking testbench for hamming_nearest_match_ratio_test: directed table, then random
// load/query sequences checked against a behavioral nearest-match predictor.
// Depends on hnm_pkg and the hamming_nearest_match_ratio_test RTL only.

module tb_hamming_nearest_match_ratio_test;
	import hnm_pkg::*;

	// Register values after reset
	localparam int RST_LEVELS    = 10;
	localparam int RST_ENTRIES   = 500;
	localparam int RST_THRESHOLD = 95;
	localparam int RST_RATIO     = 204;

	// Indexes past the last register; writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

	localparam logic [DESC_W-1:0] DESC_ZERO   = '0;
	localparam logic [DESC_W-1:0] DESC_ONES   = '1;
	localparam logic [DESC_W-1:0] DESC_STRIPE = {32{8'hA5}};

	localparam int RANDOM_ITEMS  = 60;

	typedef struct packed {
		logic                  hit;
		logic [QIDX_W-1:0]     query;
		logic [LEVEL_IN_W-1:0] lev;
		logic [ENTRY_IN_W-1:0] ent;
		logic [DIST_W-1:0]     lead_dist;
		logic [DIST_W-1:0]     next_dist;
	} match_result_t;

	typedef enum {ROW_CFG, ROW_LOAD, ROW_QUERY} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		logic [LEVEL_IN_W-1:0] lev;
		logic [ENTRY_IN_W-1:0] ent;
		logic [QIDX_W-1:0]     qidx;
		logic [DESC_W-1:0]     desc;
		bit                    typed;
		match_result_t         want;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic                  operation;
	logic [LEVEL_IN_W-1:0] level;
	logic [ENTRY_IN_W-1:0] entry_index;
	logic [QIDX_W-1:0]     query_index;
	logic [WORD_W-1:0]     word0, word1, word2, word3;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  result_valid;
	logic                  match_found;
	logic [QIDX_W-1:0]     matched_query;
	logic [LEVEL_IN_W-1:0] best_level;
	logic [ENTRY_IN_W-1:0] best_entry;
	logic [DIST_W-1:0]     best_distance;
	logic [DIST_W-1:0]     second_distance;

	// Predictor state: shadow of the pattern store and of the four registers
	logic [DESC_W-1:0] pattern_model [DEPTH];
	bit                loaded_map [DEPTH];
	logic [ALEV_W-1:0]  levels_reg;
	logic [EPL_W-1:0]   entries_reg;
	logic [THR_W-1:0]   threshold_reg;
	logic [RATIO_W-1:0] ratio_reg;

	match_result_t pending_matches [$];
	stim_row_t     plan [$];
	int            mismatch_count;
	int            sender_idle_pct;

	hamming_nearest_match_ratio_test u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.operation       (operation),
		.level           (level),
		.entry_index     (entry_index),
		.query_index     (query_index),
		.word0           (word0),
		.word1           (word1),
		.word2           (word2),
		.word3           (word3),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.result_valid    (result_valid),
		.match_found     (match_found),
		.matched_query   (matched_query),
		.best_level      (best_level),
		.best_entry      (best_entry),
		.best_distance   (best_distance),
		.second_distance (second_distance)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop: far above the slowest legal run (small scan extents, a few
	// hundred requests and register writes at the heaviest sender idling).
	initial begin
		#200000;
		$display("tb_hamming_nearest_match_ratio_test: done, errors");
		$finish;
	end

	// Search extent as the block sees it: oversized counts clamp to the store size
	function automatic int eff_levels();
		return (levels_reg > MAX_LEVELS) ? MAX_LEVELS : int'(levels_reg);
	endfunction

	function automatic int eff_entries();
		return (entries_reg > MAX_ENTRIES) ? MAX_ENTRIES : int'(entries_reg);
	endfunction

	// Scan level-major; a strictly smaller distance takes first place and
	// pushes the old best down, so the earlier entry keeps a tie.
	function automatic match_result_t nearest_match(input logic [QIDX_W-1:0] qidx,
			input logic [DESC_W-1:0] desc);
		int unsigned   best, runner, hd;
		int            best_l, best_e;
		match_result_t r;
		best   = DESC_W;
		runner = DESC_W;
		best_l = 0;
		best_e = 0;
		for (int l = 0; l < eff_levels(); l++) begin
			for (int e = 0; e < eff_entries(); e++) begin
				hd = $countones(desc ^ pattern_model[l * MAX_ENTRIES + e]);
				if (hd < best) begin
					runner = best;
					best   = hd;
					best_l = l;
					best_e = e;
				end else if (hd < runner) begin
					runner = hd;
				end
			end
		end
		r.hit       = (best < threshold_reg) && ((best << FRAC_W) < ratio_reg * runner);
		r.query     = qidx;
		r.lev       = LEVEL_IN_W'(best_l);
		r.ent       = ENTRY_IN_W'(best_e);
		r.lead_dist = DIST_W'(best);
		r.next_dist = DIST_W'(runner);
		return r;
	endfunction

	function automatic logic [DESC_W-1:0] rand_desc();
		logic [DESC_W-1:0] d;
		for (int i = 0; i < DESC_W / 32; i++) d[i * 32 +: 32] = $urandom();
		return d;
	endfunction

	// Copy a stored entry inside the search extent and flip a few bits of it;
	// an entry not loaded yet has no defined value, so start from random bits
	function automatic logic [DESC_W-1:0] near_copy(input int flips);
		logic [DESC_W-1:0] d;
		int                l, e;
		l = $urandom_range(0, eff_levels() - 1);
		e = $urandom_range(0, eff_entries() - 1);
		if (loaded_map[l * MAX_ENTRIES + e])
			d = pattern_model[l * MAX_ENTRIES + e];
		else
			d = rand_desc();
		repeat (flips) d[$urandom_range(0, DESC_W - 1)] ^= 1'b1;
		return d;
	endfunction

	function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		stim_row_t r;
		r.kind    = ROW_CFG;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	function automatic stim_row_t load_row(input logic [LEVEL_IN_W-1:0] lev,
			input logic [ENTRY_IN_W-1:0] ent, input logic [DESC_W-1:0] desc);
		stim_row_t r;
		r.kind = ROW_LOAD;
		r.lev  = lev;
		r.ent  = ent;
		r.desc = desc;
		return r;
	endfunction

	// Level and entry fields are don't-care for a query: drive them all ones
	function automatic stim_row_t query_row(input logic [QIDX_W-1:0] qidx,
			input logic [DESC_W-1:0] desc, input bit typed = 1'b0,
			input match_result_t want = '0);
		stim_row_t r;
		r.kind  = ROW_QUERY;
		r.lev   = '1;
		r.ent   = '1;
		r.qidx  = qidx;
		r.desc  = desc;
		r.typed = typed;
		r.want  = want;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		$display("tb: %0t %s: got %0h, expected %0h", $realtime, what, got, want);
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) report_mismatch(what, got, want);
	endtask

	// Present one request; hold it until the block takes it, then update the
	// shadow store (load) or queue the predicted result (query).
	task automatic send_request(input op_t op, input logic [LEVEL_IN_W-1:0] lev,
			input logic [ENTRY_IN_W-1:0] ent, input logic [QIDX_W-1:0] qidx,
			input logic [DESC_W-1:0] desc, input bit typed = 1'b0,
			input match_result_t want = '0);
		int gap;
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			gap = $urandom_range(1, 4);
			repeat (gap) begin
				@(negedge clk);
				start <= 1'b0;
			end
		end
		@(negedge clk);
		start       <= 1'b1;
		operation   <= op;
		level       <= lev;
		entry_index <= ent;
		query_index <= qidx;
		word0       <= desc[63:0];
		word1       <= desc[127:64];
		word2       <= desc[191:128];
		word3       <= desc[255:192];
		do @(posedge clk); while (busy !== 1'b0);
		if (op == OP_LOAD) begin
			pattern_model[int'(lev) * MAX_ENTRIES + int'(ent)] = desc;
			loaded_map[int'(lev) * MAX_ENTRIES + int'(ent)]    = 1'b1;
		end else begin
			pending_matches.push_back(typed ? want : nearest_match(qidx, desc));
		end
	endtask

	// Load every entry inside the search extent that was never written, so
	// that no query ever scans an undefined store word.
	task automatic fill_unwritten();
		for (int l = 0; l < eff_levels(); l++) begin
			for (int e = 0; e < eff_entries(); e++) begin
				if (!loaded_map[l * MAX_ENTRIES + e])
					send_request(OP_LOAD, LEVEL_IN_W'(l), ENTRY_IN_W'(e),
						QIDX_W'($urandom()), rand_desc());
			end
		end
	endtask

	// Registers change only with the block idle: drop start, drain every
	// pending result, let a few cycles pass, then do one write handshake.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		start <= 1'b0;
		while (pending_matches.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			CFG_ACTIVE_LEVELS: levels_reg    = val[ALEV_W-1:0];
			CFG_ENTRIES:       entries_reg   = val[EPL_W-1:0];
			CFG_THRESHOLD:     threshold_reg = val[THR_W-1:0];
			CFG_RATIO:         ratio_reg     = val[RATIO_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Result checker: every strobe must match the oldest predicted result
	always @(posedge clk) begin
		match_result_t want;
		if (arst_n && result_valid === 1'b1) begin
			if (pending_matches.size() == 0) begin
				report_mismatch("result with no query pending, matched_query",
					32'(matched_query), '0);
			end else begin
				want = pending_matches.pop_front();
				check_field("match_found", 32'(match_found), 32'(want.hit));
				check_field("matched_query", 32'(matched_query), 32'(want.query));
				check_field("best_level", 32'(best_level), 32'(want.lev));
				check_field("best_entry", 32'(best_entry), 32'(want.ent));
				check_field("best_distance", 32'(best_distance), 32'(want.lead_dist));
				check_field("second_distance", 32'(second_distance), 32'(want.next_dist));
			end
		end
	end

	initial begin
		int                    n, pick, val, random_items;
		bit                    noise, in_range;
		logic [LEVEL_IN_W-1:0] lev;
		logic [ENTRY_IN_W-1:0] ent;
		logic [DESC_W-1:0]     desc;

		// Hold every input at a known value while reset is low
		arst_n      = 1'b0;
		start       = 1'b0;
		operation   = OP_LOAD;
		level       = '0;
		entry_index = '0;
		query_index = '0;
		word0       = '0;
		word1       = '0;
		word2       = '0;
		word3       = '0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		levels_reg      = RST_LEVELS;
		entries_reg     = RST_ENTRIES;
		threshold_reg   = RST_THRESHOLD;
		ratio_reg       = RST_RATIO;
		mismatch_count  = 0;
		sender_idle_pct = 11;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table. Keep the scan extent small so few entries need loading.
		plan.push_back(load_row(4'd0, 9'd0, DESC_ZERO));
		plan.push_back(load_row(4'd15, 9'd511, DESC_ONES));
		// A write past the last register must leave the settings alone
		plan.push_back(cfg_row(CFG_UNUSED_HI, '1));
		plan.push_back(cfg_row(CFG_ENTRIES, 10'd1));
		plan.push_back(cfg_row(CFG_ACTIVE_LEVELS, 10'd1));
		// Reset threshold and ratio: an exact hit on the only entry matches
		plan.push_back(query_row(10'd0, DESC_ZERO, 1'b1,
			match_result_t'{1'b1, 10'd0, 4'd0, 9'd0, 9'd0, DIST_NONE}));
		// No levels: nothing is compared, distances stay at 256
		plan.push_back(cfg_row(CFG_ACTIVE_LEVELS, 10'd0));
		plan.push_back(query_row(10'd1023, DESC_ONES, 1'b1,
			match_result_t'{1'b0, 10'd1023, 4'd0, 9'd0, DIST_NONE, DIST_NONE}));
		// No entries: the same empty answer
		plan.push_back(cfg_row(CFG_ACTIVE_LEVELS, 10'd1));
		plan.push_back(cfg_row(CFG_ENTRIES, 10'd0));
		plan.push_back(query_row(10'd1, DESC_ZERO, 1'b1,
			match_result_t'{1'b0, 10'd1, 4'd0, 9'd0, DIST_NONE, DIST_NONE}));
		// One all-zero entry, a threshold above every distance and ratio 1.0 (256)
		plan.push_back(cfg_row(CFG_ENTRIES, 10'd1));
		plan.push_back(cfg_row(CFG_THRESHOLD, 10'd257));
		plan.push_back(cfg_row(CFG_RATIO, 10'd256));
		plan.push_back(query_row(10'd2, DESC_ZERO, 1'b1,
			match_result_t'{1'b1, 10'd2, 4'd0, 9'd0, 9'd0, DIST_NONE}));
		// Full distance: no entry beats 256, ratio test fails on equality
		plan.push_back(query_row(10'd3, DESC_ONES, 1'b1,
			match_result_t'{1'b0, 10'd3, 4'd0, 9'd0, DIST_NONE, DIST_NONE}));
		// Zero threshold: an exact hit still is no match
		plan.push_back(cfg_row(CFG_THRESHOLD, 10'd0));
		plan.push_back(query_row(10'd4, DESC_ZERO, 1'b1,
			match_result_t'{1'b0, 10'd4, 4'd0, 9'd0, 9'd0, DIST_NONE}));
		// Tie between two equal entries: the earlier one is reported
		plan.push_back(load_row(4'd0, 9'd0, DESC_STRIPE));
		plan.push_back(load_row(4'd0, 9'd1, DESC_STRIPE));
		plan.push_back(cfg_row(CFG_ENTRIES, 10'd2));
		plan.push_back(query_row(10'd5, DESC_STRIPE, 1'b1,
			match_result_t'{1'b0, 10'd5, 4'd0, 9'd0, 9'd0, 9'd0}));
		// Oversized level count clamps to all levels; zero ratio blocks every match
		plan.push_back(cfg_row(CFG_ACTIVE_LEVELS, 10'd31));
		plan.push_back(cfg_row(CFG_RATIO, 10'd0));
		plan.push_back(query_row(10'd6, DESC_ONES));

		foreach (plan[i]) begin
			case (plan[i].kind)
				ROW_CFG: begin
					write_register(plan[i].reg_idx, plan[i].reg_val);
				end
				ROW_LOAD: begin
					send_request(OP_LOAD, plan[i].lev, plan[i].ent, '0, plan[i].desc);
				end
				default: begin
					fill_unwritten();
					send_request(OP_QUERY, plan[i].lev, plan[i].ent, plan[i].qidx,
						plan[i].desc, plan[i].typed, plan[i].want);
				end
			endcase
		end

		// Random part: each round picks new settings, loads a few entries
		// (sometimes copies, to force ties) and runs queries near stored entries.
		// About one round in seven is noise: stray loads and random queries.
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			if (random_items < RANDOM_ITEMS / 3)
				sender_idle_pct = 11;
			else if (random_items < 2 * RANDOM_ITEMS / 3)
				sender_idle_pct = 61;
			else
				sender_idle_pct = 0;
			noise = ($urandom_range(0, 99) < 15);

			// Rewrite the entry count every round; keep it small so that
			// filling the scan extent stays cheap
			val = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
			write_register(CFG_ENTRIES, CFG_DATA_W'(val));
			if ($urandom_range(0, 1)) begin
				pick = $urandom_range(0, 7);
				val  = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(16, 31)
					: $urandom_range(1, 4);
				write_register(CFG_ACTIVE_LEVELS, CFG_DATA_W'(val));
			end
			if ($urandom_range(0, 1)) begin
				pick = $urandom_range(0, 9);
				val  = (pick == 0) ? $urandom_range(0, 1023) : (pick < 5)
					? $urandom_range(0, 257) : $urandom_range(10, 100);
				write_register(CFG_THRESHOLD, CFG_DATA_W'(val));
			end
			if ($urandom_range(0, 1)) begin
				val = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
					: $urandom_range(0, 256);
				write_register(CFG_RATIO, CFG_DATA_W'(val));
			end
			if ($urandom_range(0, 9) == 0)
				write_register(CFG_IDX_W'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)),
					CFG_DATA_W'($urandom()));

			in_range = (eff_levels() > 0) && (eff_entries() > 0);
			n = $urandom_range(0, 3);
			repeat (n) begin
				if (noise || !in_range) begin
					lev  = LEVEL_IN_W'($urandom());
					ent  = ENTRY_IN_W'($urandom());
					desc = rand_desc();
				end else begin
					lev  = LEVEL_IN_W'($urandom_range(0, eff_levels() - 1));
					ent  = ENTRY_IN_W'($urandom_range(0, eff_entries() - 1));
					desc = $urandom_range(0, 1) ? near_copy($urandom_range(0, 3))
						: rand_desc();
				end
				send_request(OP_LOAD, lev, ent, QIDX_W'($urandom()), desc);
				random_items++;
			end

			n = $urandom_range(1, 4);
			repeat (n) begin
				pick = $urandom_range(0, 9);
				if (!noise && in_range && pick < 7)
					desc = near_copy($urandom_range(0, 48));
				else if (pick < 9 || noise)
					desc = rand_desc();
				else
					desc = $urandom_range(0, 1) ? DESC_ONES : DESC_ZERO;
				fill_unwritten();
				send_request(OP_QUERY, LEVEL_IN_W'($urandom()), ENTRY_IN_W'($urandom()),
					QIDX_W'($urandom()), desc);
				random_items++;
			end
		end

		// Drain: release the request line, wait for the last result, then
		// watch a little longer for stray strobes.
		@(negedge clk);
		start <= 1'b0;
		while (pending_matches.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb_hamming_nearest_match_ratio_test: done, clean");
		end else begin
			$display("tb_hamming_nearest_match_ratio_test: done, errors");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/core/hnm_pkg.sv
rtl/core/hnm_ram.sv
rtl/core/hnm_dist.sv
rtl/core/hamming_nearest_match_ratio_test.sv
tb/tb_hamming_nearest_match_ratio_test.sv
